### rtl/narsc_pkg.sv
package narsc_pkg;

    typedef struct packed {
        logic        kind;
        logic [8:0]  ray_slot;
        logic [15:0] azimuth_centideg;
    } t_req;

    typedef struct packed {
        logic [8:0] nearest_ray;
        logic       spacing_zero;
    } t_rsp;

    localparam int          MAX_RAYS_DEF   = 512;
    localparam logic [9:0]  NUM_RAYS_RESET = 10'd360;
    localparam int          QUEUE_DEPTH    = 2;

    localparam logic        KIND_LOAD  = 1'b0;
    localparam logic        KIND_QUERY = 1'b1;

    // spacing reference entry and scales of the fixed-point search
    localparam int          SPACING_SLOT = 50;
    localparam int          JUMP_SCALE   = 50;
    localparam int          STOP_SCALE   = 100;

    localparam int                 DIFF_W    = 18;
    localparam logic signed [17:0] HALF_TURN = 18'sd18000;
    localparam logic signed [17:0] FULL_TURN = 18'sd36000;

endpackage

### rtl/narsc_fifo.sv
module narsc_fifo
    import narsc_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [NW-1:0] r_cnt;
    logic [NW-1:0] n_cnt;
    logic [PW-1:0] n_wp;
    logic [PW-1:0] n_rp;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + NW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - NW'(1);
        end
        n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
        n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### rtl/narsc_front.sv
module narsc_front
    import narsc_pkg::*;
#(
    parameter int MAX_RAYS = MAX_RAYS_DEF,
    localparam int AW = $clog2(MAX_RAYS),
    localparam int CW = $clog2(MAX_RAYS + 1),
    localparam int QW = 1 + AW + 16
) (
    input  logic          i_valid,
    output logic          o_ready,
    input  t_req          i_req,
    input  logic [9:0]    i_num_rays,
    output logic [CW-1:0] o_count,
    output logic          o_push,
    output logic [QW-1:0] o_push_data,
    input  logic          i_full
);

    localparam int XW = CW + 10;

    logic [XW-1:0] nr;
    logic [XW-1:0] cnt;
    logic [XW-1:0] last;
    logic [XW-1:0] slot;
    logic [XW-1:0] idx;
    logic          keep;

    always_comb begin
        nr = XW'(i_num_rays);
        if (nr == '0) begin
            cnt = XW'(1);
        end else if (nr > XW'(MAX_RAYS)) begin
            cnt = XW'(MAX_RAYS);
        end else begin
            cnt = nr;
        end
        last = cnt - XW'(1);
        slot = XW'(i_req.ray_slot);
        if (i_req.kind == KIND_QUERY) begin
            idx  = (slot > last) ? last : slot;
            keep = 1'b1;
        end else begin
            idx  = slot;
            keep = (slot < XW'(MAX_RAYS));
        end
    end

    assign o_count     = cnt[CW-1:0];
    assign o_ready     = !i_full;
    // out-of-range loads are accepted and dropped here
    assign o_push      = i_valid && !i_full && keep;
    assign o_push_data = {i_req.kind, idx[AW-1:0], i_req.azimuth_centideg};

endmodule

### rtl/narsc_back.sv
module narsc_back
    import narsc_pkg::*;
#(
    parameter int MAX_RAYS = MAX_RAYS_DEF,
    localparam int AW = $clog2(MAX_RAYS),
    localparam int CW = $clog2(MAX_RAYS + 1),
    localparam int QW = 1 + AW + 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [CW-1:0] i_count,
    input  logic          i_q_valid,
    input  logic [QW-1:0] i_q_data,
    output logic          o_q_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output t_rsp          o_rsp
);

    localparam int MW  = 15;          // magnitude of a folded difference
    localparam int DW  = MW + 6;      // magnitude times the jump scale
    localparam int FW  = MW + 7;      // magnitude times the stop scale
    localparam int DCW = $clog2(DW + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_MATCH, S_PREP, S_DIV, S_JUMP,
        S_RD1, S_AIM, S_TEST, S_WRD, S_WUPD, S_EMIT
    } t_state;

    function automatic logic signed [DIFF_W-1:0] fold(input logic signed [DIFF_W-1:0] d);
        logic signed [DIFF_W-1:0] r;
        r = d;
        if (d >= HALF_TURN) begin
            r = d - FULL_TURN;
        end else if (d < -HALF_TURN) begin
            r = d + FULL_TURN;
        end
        return r;
    endfunction

    t_state                    r_state;
    logic [AW-1:0]             r_idx;
    logic [15:0]               r_tgt;
    logic signed [DIFF_W-1:0]  r_d;
    logic signed [DIFF_W-1:0]  r_spc;
    logic [DW-1:0]             r_dvd;
    logic [MW-1:0]             r_rem;
    logic [DCW-1:0]            r_cnt;
    logic [CW-1:0]             r_jm;
    logic [CW-1:0]             r_steps;
    logic                      r_lastdir;
    logic                      r_brk;
    logic                      r_sz;
    logic [15:0]               r_az0;
    logic [15:0]               r_az50;
    logic                      r_ovalid;
    t_rsp                      r_rsp;
    logic [15:0]               r_mem [MAX_RAYS];
    logic [15:0]               r_rdata;

    logic                      q_kind;
    logic [AW-1:0]             q_idx;
    logic [15:0]               q_az;
    logic                      mem_we;
    logic signed [DIFF_W-1:0]  d_new;
    logic signed [DIFF_W-1:0]  s_raw;
    logic signed [DIFF_W-1:0]  s_abs;
    logic signed [DIFF_W-1:0]  s_new;
    logic signed [DIFF_W-1:0]  d_neg;
    logic [MW-1:0]             d_mag;
    logic [MW:0]               rem_sh;
    logic                      q_bit;
    logic [MW-1:0]             n_rem;
    logic [CW:0]               jm2;
    logic [CW-1:0]             n_jm;
    logic [CW:0]               idx_ext;
    logic [CW:0]               j_sum;
    logic [CW-1:0]             n_idx_jump;
    logic [CW-1:0]             n_idx_step;
    logic                      dir;
    logic                      far;
    logic [AW+8:0]             idx_wide;

    assign q_kind = i_q_data[QW-1];
    assign q_idx  = i_q_data[QW-2 -: AW];
    assign q_az   = i_q_data[15:0];

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign mem_we  = o_q_pop && (q_kind == KIND_LOAD);

    always_comb begin
        d_new  = fold($signed({2'b00, r_tgt}) - $signed({2'b00, r_rdata}));
        s_raw  = $signed({2'b00, r_az0}) - $signed({2'b00, r_az50});
        s_abs  = s_raw[DIFF_W-1] ? -s_raw : s_raw;
        s_new  = (s_abs > HALF_TURN) ? FULL_TURN - s_abs : s_abs;
        d_neg  = -r_d;
        d_mag  = r_d[DIFF_W-1] ? d_neg[MW-1:0] : r_d[MW-1:0];

        rem_sh = {r_rem, r_dvd[DW-1]};
        q_bit  = (rem_sh >= {1'b0, r_spc[MW-1:0]});
        n_rem  = q_bit ? MW'(rem_sh - {1'b0, r_spc[MW-1:0]}) : rem_sh[MW-1:0];
        jm2    = {r_jm, 1'b0} + (CW+1)'(q_bit);
        n_jm   = (jm2 >= {1'b0, i_count}) ? CW'(jm2 - {1'b0, i_count}) : jm2[CW-1:0];

        idx_ext = (CW+1)'(r_idx);
        if (!r_d[DIFF_W-1]) begin
            j_sum      = idx_ext + {1'b0, r_jm};
            n_idx_jump = (j_sum >= {1'b0, i_count}) ? CW'(j_sum - {1'b0, i_count})
                                                    : j_sum[CW-1:0];
        end else begin
            j_sum      = idx_ext - {1'b0, r_jm};
            n_idx_jump = j_sum[CW] ? CW'(j_sum + {1'b0, i_count}) : j_sum[CW-1:0];
        end

        dir = !r_d[DIFF_W-1];
        if (dir) begin
            n_idx_step = (idx_ext[CW-1:0] + CW'(1) == i_count) ? '0
                                                               : idx_ext[CW-1:0] + CW'(1);
        end else begin
            n_idx_step = (r_idx == '0) ? i_count - CW'(1) : idx_ext[CW-1:0] - CW'(1);
        end

        far      = (FW'(d_mag) * FW'(STOP_SCALE)) > FW'(r_spc[MW-1:0]);
        idx_wide = {{9{1'b0}}, r_idx};
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[q_idx] <= q_az;
        end
        r_rdata <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && (r_state != S_EMIT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        if (q_kind == KIND_LOAD) begin
                            if (q_idx == '0) begin
                                r_az0 <= q_az;
                            end
                            if (q_idx == AW'(SPACING_SLOT)) begin
                                r_az50 <= q_az;
                            end
                        end else begin
                            r_idx   <= q_idx;
                            r_tgt   <= q_az;
                            r_state <= S_RD0;
                        end
                    end
                end
                S_RD0: begin
                    r_state <= S_MATCH;
                end
                S_MATCH: begin
                    r_sz <= 1'b0;
                    if (r_rdata == r_tgt) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_d     <= d_new;
                        r_spc   <= s_new;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (r_spc[DIFF_W-1] || r_spc == '0) begin
                        r_sz    <= 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        r_dvd   <= DW'(d_mag) * DW'(JUMP_SCALE);
                        r_rem   <= '0;
                        r_jm    <= '0;
                        r_cnt   <= DCW'(DW);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // restoring divide, quotient reduced modulo the ray count on the fly
                    r_rem <= n_rem;
                    r_jm  <= n_jm;
                    r_dvd <= {r_dvd[DW-2:0], 1'b0};
                    r_cnt <= r_cnt - DCW'(1);
                    if (r_cnt == DCW'(1)) begin
                        r_state <= S_JUMP;
                    end
                end
                S_JUMP: begin
                    r_idx   <= n_idx_jump[AW-1:0];
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_state <= S_AIM;
                end
                S_AIM: begin
                    r_d       <= d_new;
                    r_lastdir <= !d_new[DIFF_W-1];
                    r_steps   <= '0;
                    r_brk     <= 1'b0;
                    r_state   <= S_TEST;
                end
                S_TEST: begin
                    if (r_brk || !far || r_steps >= i_count) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_steps   <= r_steps + CW'(1);
                        r_idx     <= n_idx_step[AW-1:0];
                        r_brk     <= (dir != r_lastdir);
                        r_lastdir <= dir;
                        r_state   <= S_WRD;
                    end
                end
                S_WRD: begin
                    r_state <= S_WUPD;
                end
                S_WUPD: begin
                    r_d     <= d_new;
                    r_state <= S_TEST;
                end
                S_EMIT: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid           <= 1'b1;
                        r_rsp.nearest_ray  <= idx_wide[8:0];
                        r_rsp.spacing_zero <= r_sz;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;

endmodule

### rtl/nearest_azimuth_ray_search_core.sv
// Nearest azimuth ray search.
// Input channel (i_in_valid / o_in_ready / i_in_req): a request either loads one
// azimuth table entry (kind load) or asks for the ray nearest a target azimuth
// from a start index (kind query). Loads give no response; each query gives one
// response on o_out_valid / i_out_ready / o_out_rsp, in request order.
// num_rays is written through i_cfg_we / i_cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce. Requests pass a
// two-entry queue into a sequencer working on one request at a time from a table
// memory with one write port and one read port. A load is written without the
// sequencer leaving idle. A query first checks the start entry for an exact hit and
// responds on zero or negative spacing; otherwise it runs a bit-serial spacing
// divide, then single-ray steps, one table read per step.
// Reset empties the queue, returns the sequencer to idle, drops any pending
// response and sets num_rays to 360; table contents are not cleared.
// A stalled receiver holds the response register; the sequencer finishes its
// current request and waits, while the queue keeps taking requests until full.
module nearest_azimuth_ray_search_core
    import narsc_pkg::*;
#(
    parameter int MAX_RAYS = MAX_RAYS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_req       i_in_req,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_rsp       o_out_rsp,
    input  logic       i_cfg_we,
    input  logic [9:0] i_cfg_wdata
);

    localparam int AW = $clog2(MAX_RAYS);
    localparam int CW = $clog2(MAX_RAYS + 1);
    localparam int QW = 1 + AW + 16;

    logic [9:0]    r_num_rays;
    logic [CW-1:0] count;
    logic          push;
    logic [QW-1:0] push_data;
    logic          full;
    logic          q_valid;
    logic [QW-1:0] q_data;
    logic          q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rays <= NUM_RAYS_RESET;
        end else if (i_cfg_we) begin
            r_num_rays <= i_cfg_wdata;
        end
    end

    narsc_front #(
        .MAX_RAYS (MAX_RAYS)
    ) u_front (
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_req       (i_in_req),
        .i_num_rays  (r_num_rays),
        .o_count     (count),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (full)
    );

    narsc_fifo #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    narsc_back #(
        .MAX_RAYS (MAX_RAYS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_count   (count),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_rsp     (o_out_rsp)
    );

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import narsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int TAIL_CYCLES    = 40;

    class nearest_ray_board;
        logic [15:0] az_tab [MAX_RAYS_DEF];
        logic [9:0]  ray_cfg;
        t_rsp        awaited [$];
        int          n_errors;

        function new();
            ray_cfg  = NUM_RAYS_RESET;
            n_errors = 0;
            foreach (az_tab[i]) az_tab[i] = '0;
        endfunction

        // one fold into [-half turn, +half turn)
        function automatic longint fold_turn(longint d);
            if (d >= longint'(HALF_TURN)) return d - longint'(FULL_TURN);
            if (d < -longint'(HALF_TURN)) return d + longint'(FULL_TURN);
            return d;
        endfunction

        function automatic t_rsp search(logic [8:0] slot, logic [15:0] target);
            longint cnt, idx, spc, d, jump, steps, dir, last_dir;
            t_rsp   r;
            cnt = longint'(ray_cfg);
            if (cnt < 1) cnt = 1;
            if (cnt > MAX_RAYS_DEF) cnt = MAX_RAYS_DEF;
            idx = longint'(slot);
            if (idx > cnt - 1) idx = cnt - 1;
            r.spacing_zero = 1'b0;
            r.nearest_ray  = idx[8:0];
            if (az_tab[idx] == target) return r;

            // fifty times the ray spacing, folded to a half turn
            spc = longint'(az_tab[0]) - longint'(az_tab[SPACING_SLOT]);
            if (spc < 0) spc = -spc;
            if (spc > longint'(HALF_TURN)) spc = longint'(FULL_TURN) - spc;
            if (spc <= 0) begin
                r.spacing_zero = 1'b1;
                return r;
            end

            d    = fold_turn(longint'(target) - longint'(az_tab[idx]));
            jump = (d * JUMP_SCALE) / spc;
            idx  = (idx + jump) % cnt;
            if (idx < 0) idx += cnt;
            d = fold_turn(longint'(target) - longint'(az_tab[idx]));

            last_dir = (d >= 0) ? 1 : -1;
            steps    = 0;
            while (((d < 0) ? -d : d) * STOP_SCALE > spc && steps < cnt) begin
                steps++;
                dir = (d >= 0) ? 1 : -1;
                idx += dir;
                if (idx >= cnt) idx -= cnt;
                if (idx < 0) idx += cnt;
                d = fold_turn(longint'(target) - longint'(az_tab[idx]));
                if (dir != last_dir) break;
                last_dir = dir;
            end
            r.nearest_ray = idx[8:0];
            return r;
        endfunction

        function void note_req(t_req q);
            if (q.kind == KIND_LOAD) az_tab[q.ray_slot] = q.azimuth_centideg;
            else awaited.push_back(search(q.ray_slot, q.azimuth_centideg));
        endfunction

        function void check_rsp(t_rsp got);
            t_rsp want;
            if (awaited.size() == 0) begin
                $error("unexpected response: nearest_ray %0d spacing_zero %0d",
                       got.nearest_ray, got.spacing_zero);
                n_errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.nearest_ray !== want.nearest_ray) begin
                $error("nearest_ray: expected %0d, actual %0d",
                       want.nearest_ray, got.nearest_ray);
                n_errors++;
            end
            if (got.spacing_zero !== want.spacing_zero) begin
                $error("spacing_zero: expected %0d, actual %0d",
                       want.spacing_zero, got.spacing_zero);
                n_errors++;
            end
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    t_req       req       = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b1;
    t_rsp       rsp;
    logic       cfg_we    = 1'b0;
    logic [9:0] cfg_wdata = '0;

    nearest_ray_board board;
    bit               calm = 1'b0;
    int               quiet_cycles = 0;

    nearest_azimuth_ray_search_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_ready  (req_ready),
        .i_in_req    (req),
        .o_out_valid (rsp_valid),
        .i_out_ready (rsp_ready),
        .o_out_rsp   (rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && rsp_valid && rsp_ready) board.check_rsp(rsp);
        rsp_ready <= calm || ($urandom_range(0, 99) >= 6);
    end

    always @(posedge clk) begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send(logic kind, int slot, int az);
        t_req q;
        q.kind             = kind;
        q.ray_slot         = slot[8:0];
        q.azimuth_centideg = az[15:0];
        if (!calm && $urandom_range(0, 99) < 6) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= q;
        do @(posedge clk); while (!req_ready);
        board.note_req(q);
    endtask

    task automatic drain(int settle);
        req_valid <= 1'b0;
        while (board.awaited.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_ray_count(logic [9:0] value);
        drain(SETTLE_CYCLES);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.ray_cfg = value;
    endtask

    // evenly spaced sweep with a little jitter, either direction
    task automatic load_sweep(int rays, int entries);
        int base, pitch, dir, jit, az;
        base  = int'($urandom_range(0, 35999));
        pitch = 36000 / rays;
        dir   = ($urandom_range(0, 1) == 1) ? 1 : -1;
        for (int i = 0; i < entries; i++) begin
            jit = int'($urandom_range(0, pitch / 4)) - pitch / 8;
            az  = (base + dir * i * pitch + jit) % 36000;
            if (az < 0) az += 36000;
            send(KIND_LOAD, i, az);
        end
    endtask

    task automatic random_query(int rays);
        int slot, az, pick;
        pick = int'($urandom_range(0, 99));
        if ($urandom_range(0, 9) < 8) slot = int'($urandom_range(0, rays - 1));
        else slot = int'($urandom_range(0, MAX_RAYS_DEF - 1));
        if (pick < 15) begin
            az = int'(board.az_tab[$urandom_range(0, rays - 1)]);
        end else if (pick < 25) begin
            az = (int'(board.az_tab[$urandom_range(0, rays - 1)])
                  + int'($urandom_range(0, 300)) + 35850) % 36000;
        end else if (pick < 30) begin
            az = int'($urandom_range(36000, 65535));
        end else if (pick < 34) begin
            az = pick[0] ? 0 : 35999;
        end else begin
            az = int'($urandom_range(0, 35999));
        end
        send(KIND_QUERY, slot, az);
    endtask

    task automatic run_phase(int cfg, bit reload, int queries, bit pause_midway);
        int rays, done;
        write_ray_count(cfg[9:0]);
        rays = (cfg == 0) ? 1 : (cfg > MAX_RAYS_DEF) ? MAX_RAYS_DEF : cfg;
        if (reload) load_sweep(rays, (rays > SPACING_SLOT) ? rays : SPACING_SLOT + 1);
        done = 0;
        while (done < queries) begin
            if ($urandom_range(0, 99) < 8) begin
                send(KIND_LOAD, int'($urandom_range(0, MAX_RAYS_DEF - 1)),
                     ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 65535))
                                                 : int'($urandom_range(0, 35999)));
            end else begin
                random_query(rays);
                done++;
                if (pause_midway && done == queries / 2) drain(0);
            end
        end
    endtask

    initial begin
        int s0, s50;
        board = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // whole table written once so no entry is ever read unwritten
        load_sweep(360, MAX_RAYS_DEF);

        send(KIND_QUERY, 7, int'(board.az_tab[7]));
        send(KIND_QUERY, 511, 0);
        send(KIND_QUERY, 0, 35999);
        send(KIND_QUERY, 359, int'(board.az_tab[0]));
        send(KIND_QUERY, 1, (int'(board.az_tab[358]) + 5) % 36000);
        send(KIND_QUERY, 200, 65535);
        send(KIND_QUERY, 100, (int'(board.az_tab[100]) + 18000) % 36000);
        send(KIND_QUERY, 180, (int'(board.az_tab[180]) + int'(board.az_tab[181])) / 2);
        send(KIND_QUERY, 511, int'(board.az_tab[359]));
        send(KIND_LOAD, 511, 35999);
        s0  = int'(board.az_tab[0]);
        s50 = int'(board.az_tab[SPACING_SLOT]);
        // zero spacing, then negative spacing from an out-of-range entry
        send(KIND_LOAD, SPACING_SLOT, s0);
        send(KIND_QUERY, 20, (int'(board.az_tab[20]) + 1) % 36000);
        send(KIND_LOAD, 0, 0);
        send(KIND_LOAD, SPACING_SLOT, 65535);
        send(KIND_QUERY, 300, 12345);
        send(KIND_LOAD, 0, s0);
        send(KIND_LOAD, SPACING_SLOT, s50);
        send(KIND_QUERY, 0, (s0 + 1) % 36000);

        run_phase(512, 1'b0, 140, 1'b0);
        run_phase(1023, 1'b0, 50, 1'b0);
        calm = 1'b1;
        run_phase(360, 1'b0, 140, 1'b0);
        calm = 1'b0;
        run_phase(51, 1'b1, 120, 1'b1);
        run_phase(0, 1'b0, 50, 1'b0);
        run_phase(97, 1'b1, 110, 1'b0);
        run_phase(int'($urandom_range(51, 300)), 1'b1, 110, 1'b0);
        run_phase(int'($urandom_range(51, 128)), 1'b1, 110, 1'b0);

        drain(TAIL_CYCLES);
        if (board.n_errors == 0 && board.awaited.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
